// ----- hdl/assert_macros.svh -----
// assertion macros for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked while reset is high
`define PSX_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, masked while reset is high
`define PSX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// next-cycle implication that also holds through reset
`define PSX_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hdl/psx_pkg.sv -----
`default_nettype none

package psx_pkg;

   // frame and element limits
   localparam int SSID_MAX_BYTES  = 32;
   localparam int MAX_FRAME_BYTES = 4095;
   localparam int MIN_FRAME_BYTES = 26;
   localparam int HDR_LAST_POS    = 23;

   // widths
   localparam int IDX_W   = (SSID_MAX_BYTES > 1) ? $clog2(SSID_MAX_BYTES) : 1;
   localparam int LEN_W   = 6;
   localparam int CNT_W   = $clog2(MAX_FRAME_BYTES + 2);
   localparam int ADDR_W  = IDX_W + 1;
   localparam int MEM_DEPTH = 2 << IDX_W;

   // byte constants
   localparam logic [7:0] FC_TYPE_MASK     = 8'h0C;
   localparam logic [3:0] FC_SUBTYPE_PROBE = 4'h4;
   localparam logic [7:0] CHAR_LOW         = 8'h20;
   localparam logic [7:0] CHAR_DEL         = 8'h7F;
   localparam logic [7:0] CHAR_SUB         = 8'h3F;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HEADER,
      PH_EXPECT_ID,
      PH_EXPECT_LEN,
      PH_SKIP,
      PH_SSID,
      PH_DECIDED
   } phase_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED  = 4'd0,
      ST_REJECTED  = 4'd1,
      ST_TOO_SHORT = 4'd2,
      ST_NOT_PROBE = 4'd3,
      ST_NO_SSID   = 4'd4,
      ST_OVERRUN   = 4'd5,
      ST_WILDCARD  = 4'd6,
      ST_HIDDEN    = 4'd7,
      ST_OVERSIZE  = 4'd8
   } status_type;

   // ssid buffer write from the parser
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   // end-of-frame result job handed to the output side
   typedef struct packed {
      logic             valid;
      status_type       status;
      logic [LEN_W-1:0] length;
      logic             bank;
   } job_type;

endpackage

`default_nettype wire

// ----- hdl/psx_req_if.sv -----
`default_nettype none

interface psx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_frame;
   logic       end_of_frame;
   logic       is_management;

   modport source (
      output valid, data_byte, start_of_frame, end_of_frame, is_management,
      input  ready
   );

   modport sink (
      input  valid, data_byte, start_of_frame, end_of_frame, is_management,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/psx_rsp_if.sv -----
`default_nettype none

interface psx_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] status;
   logic [7:0] ssid_char;
   logic [5:0] ssid_length;
   logic       last_result;

   modport source (
      output valid, status, ssid_char, ssid_length, last_result,
      input  ready
   );

   modport sink (
      input  valid, status, ssid_char, ssid_length, last_result,
      output ready
   );
endinterface

`default_nettype wire

// ----- hdl/probe_request_ssid_extractor.sv -----
`default_nettype none

// Probe request SSID extractor. Takes an 802.11 frame one byte per word on req_bus and,
// at the frame's last byte, reports either the SSID characters as a run of words (status
// accepted, control bytes and 0x7F shown as '?', last_result on the final one) or a single
// status word. Bytes are taken one per cycle. A frame's last byte waits only while the
// previous frame's result words (an SSID run of up to 32 words, or one status word) are
// still being issued into the two-stage output pipeline, one per cycle unless stalled;
// two SSID buffers are ping-ponged, so the next frame's SSID bytes never wait. After the
// last byte is taken, the result passes the job register, stage one and the output
// register in turn. capture_enable is written through csr_write_enable/csr_write_data
// and is sampled with each frame's first byte. There is no clearing pass after reset.
module probe_request_ssid_extractor (
   input  wire logic    clock,
   input  wire logic    reset,
   psx_req_if.sink      req_bus,
   psx_rsp_if.source    rsp_bus,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   logic                capture_enable_ff;
   logic                slot_free;
   logic                accept;
   psx_pkg::wr_type     wr;
   psx_pkg::job_type    job;

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         capture_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         capture_enable_ff <= csr_write_data;
      end
   end

   // only an end-of-frame byte can wait on the output side
   assign req_bus.ready = !req_bus.end_of_frame || slot_free;
   assign accept        = req_bus.valid && req_bus.ready;

   psx_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .capture_enable (capture_enable_ff),
      .accept         (accept),
      .data_byte      (req_bus.data_byte),
      .start_of_frame (req_bus.start_of_frame),
      .end_of_frame   (req_bus.end_of_frame),
      .is_management  (req_bus.is_management),
      .wr             (wr),
      .job            (job)
   );

   psx_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .job        (job),
      .slot_free  (slot_free),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_bus.status),
      .rsp_char   (rsp_bus.ssid_char),
      .rsp_length (rsp_bus.ssid_length),
      .rsp_last   (rsp_bus.last_result)
   );

endmodule

`default_nettype wire

// ----- hdl/psx_parser.sv -----
`default_nettype none

module psx_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  capture_enable,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  start_of_frame,
   input  wire logic                  end_of_frame,
   input  wire logic                  is_management,
   output psx_pkg::wr_type            wr,
   output psx_pkg::job_type           job
);

   psx_pkg::phase_type               phase_ff, phase_in, phase_cur;
   logic [psx_pkg::CNT_W-1:0]        cnt_ff, cnt_in, cnt_cur;
   logic                             mgmt_ff, mgmt_in, mgmt_cur;
   logic                             enable_ff, enable_in, enable_cur;
   logic                             probe_ff, probe_in, probe_cur;
   logic [7:0]                       eid_ff, eid_in, eid_cur;
   logic [7:0]                       rem_ff, rem_in, rem_cur;
   logic [psx_pkg::LEN_W-1:0]        kept_ff, kept_in, kept_cur;
   logic                             zero_ff, zero_in, zero_cur;
   psx_pkg::status_type              outcome_ff, outcome_in, outcome_cur;
   logic                             bank_ff, bank_in;
   psx_pkg::status_type              status;

   // frame start view of the state
   always_comb begin
      if (start_of_frame) begin
         phase_cur   = psx_pkg::PH_HEADER;
         cnt_cur     = '0;
         mgmt_cur    = is_management;
         enable_cur  = capture_enable;
         probe_cur   = 1'b0;
         eid_cur     = '0;
         rem_cur     = '0;
         kept_cur    = '0;
         zero_cur    = 1'b1;
         outcome_cur = psx_pkg::ST_ACCEPTED;
      end else begin
         phase_cur   = phase_ff;
         cnt_cur     = cnt_ff;
         mgmt_cur    = mgmt_ff;
         enable_cur  = enable_ff;
         probe_cur   = probe_ff;
         eid_cur     = eid_ff;
         rem_cur     = rem_ff;
         kept_cur    = kept_ff;
         zero_cur    = zero_ff;
         outcome_cur = outcome_ff;
      end
   end

   // element walk for one word
   always_comb begin
      phase_in   = phase_cur;
      cnt_in     = cnt_cur;
      mgmt_in    = mgmt_cur;
      enable_in  = enable_cur;
      probe_in   = probe_cur;
      eid_in     = eid_cur;
      rem_in     = rem_cur;
      kept_in    = kept_cur;
      zero_in    = zero_cur;
      outcome_in = outcome_cur;
      bank_in    = bank_ff;
      wr.en      = 1'b0;
      wr.addr    = {bank_ff, kept_cur[psx_pkg::IDX_W-1:0]};
      wr.data    = ((data_byte >= psx_pkg::CHAR_LOW) && (data_byte != psx_pkg::CHAR_DEL))
                   ? data_byte : psx_pkg::CHAR_SUB;
      status     = psx_pkg::ST_NO_SSID;
      job.valid  = 1'b0;
      job.status = psx_pkg::ST_NO_SSID;
      job.length = '0;
      job.bank   = bank_ff;

      if (phase_cur != psx_pkg::PH_IDLE) begin
         // saturating byte count
         if (cnt_cur <= psx_pkg::CNT_W'(psx_pkg::MAX_FRAME_BYTES)) begin
            cnt_in = cnt_cur + 1'b1;
         end

         case (phase_cur)
            psx_pkg::PH_HEADER: begin
               if ((cnt_cur == '0) && ((data_byte & psx_pkg::FC_TYPE_MASK) == '0) &&
                   (data_byte[7:4] == psx_pkg::FC_SUBTYPE_PROBE)) begin
                  probe_in = 1'b1;
               end
               if (cnt_cur >= psx_pkg::CNT_W'(psx_pkg::HDR_LAST_POS)) begin
                  phase_in = psx_pkg::PH_EXPECT_ID;
               end
            end
            psx_pkg::PH_EXPECT_ID: begin
               eid_in   = data_byte;
               phase_in = psx_pkg::PH_EXPECT_LEN;
            end
            psx_pkg::PH_EXPECT_LEN: begin
               if (eid_cur == '0) begin
                  if (data_byte == '0) begin
                     outcome_in = psx_pkg::ST_WILDCARD;
                     phase_in   = psx_pkg::PH_DECIDED;
                  end else begin
                     rem_in   = data_byte;
                     kept_in  = '0;
                     zero_in  = 1'b1;
                     phase_in = psx_pkg::PH_SSID;
                  end
               end else if (data_byte == '0) begin
                  phase_in = psx_pkg::PH_EXPECT_ID;
               end else begin
                  rem_in   = data_byte;
                  phase_in = psx_pkg::PH_SKIP;
               end
            end
            psx_pkg::PH_SKIP: begin
               rem_in = rem_cur - 1'b1;
               if (rem_cur == 8'd1) begin
                  phase_in = psx_pkg::PH_EXPECT_ID;
               end
            end
            psx_pkg::PH_SSID: begin
               if (kept_cur < psx_pkg::LEN_W'(psx_pkg::SSID_MAX_BYTES)) begin
                  if (data_byte != '0) begin
                     zero_in = 1'b0;
                  end
                  wr.en   = 1'b1;
                  kept_in = kept_cur + 1'b1;
               end
               rem_in = rem_cur - 1'b1;
               if (rem_cur == 8'd1) begin
                  outcome_in = zero_in ? psx_pkg::ST_HIDDEN : psx_pkg::ST_ACCEPTED;
                  phase_in   = psx_pkg::PH_DECIDED;
               end
            end
            default: begin
            end
         endcase

         // end of frame verdict, in priority order
         if (!enable_in || !mgmt_in) begin
            status = psx_pkg::ST_REJECTED;
         end else if (cnt_in > psx_pkg::CNT_W'(psx_pkg::MAX_FRAME_BYTES)) begin
            status = psx_pkg::ST_OVERSIZE;
         end else if (cnt_in < psx_pkg::CNT_W'(psx_pkg::MIN_FRAME_BYTES)) begin
            status = psx_pkg::ST_TOO_SHORT;
         end else if (!probe_in) begin
            status = psx_pkg::ST_NOT_PROBE;
         end else if (phase_in == psx_pkg::PH_DECIDED) begin
            status = outcome_in;
         end else if ((phase_in == psx_pkg::PH_SKIP) || (phase_in == psx_pkg::PH_SSID)) begin
            status = psx_pkg::ST_OVERRUN;
         end else begin
            status = psx_pkg::ST_NO_SSID;
         end

         if (end_of_frame) begin
            phase_in   = psx_pkg::PH_IDLE;
            job.valid  = accept;
            job.status = status;
            if (status == psx_pkg::ST_ACCEPTED) begin
               job.length = kept_in;
               bank_in    = ~bank_ff;
            end
         end
      end

      wr.en = wr.en & accept;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= psx_pkg::PH_IDLE;
         cnt_ff     <= '0;
         mgmt_ff    <= 1'b0;
         enable_ff  <= 1'b0;
         probe_ff   <= 1'b0;
         eid_ff     <= '0;
         rem_ff     <= '0;
         kept_ff    <= '0;
         zero_ff    <= 1'b1;
         outcome_ff <= psx_pkg::ST_ACCEPTED;
         bank_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         mgmt_ff    <= mgmt_in;
         enable_ff  <= enable_in;
         probe_ff   <= probe_in;
         eid_ff     <= eid_in;
         rem_ff     <= rem_in;
         kept_ff    <= kept_in;
         zero_ff    <= zero_in;
         outcome_ff <= outcome_in;
         bank_ff    <= bank_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/psx_drain.sv -----
`default_nettype none

module psx_drain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire psx_pkg::wr_type       wr,
   input  wire psx_pkg::job_type      job,
   output logic                       slot_free,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output logic [3:0]                 rsp_status,
   output logic [7:0]                 rsp_char,
   output logic [5:0]                 rsp_length,
   output logic                       rsp_last
);

   // two ssid banks, parser fills one while the other streams out
   logic [7:0]                  mem [psx_pkg::MEM_DEPTH];
   logic [7:0]                  mem_rd_ff;

   logic                        busy_ff;
   psx_pkg::status_type         jstat_ff;
   logic [psx_pkg::LEN_W-1:0]   jlen_ff;
   logic                        jbank_ff;
   logic [psx_pkg::IDX_W-1:0]   idx_ff;

   logic                        s1_valid_ff;
   psx_pkg::status_type         s1_status_ff;
   logic [psx_pkg::LEN_W-1:0]   s1_len_ff;
   logic                        s1_last_ff;
   logic                        s1_char_ff;

   logic                        out_valid_ff;
   psx_pkg::status_type         out_status_ff;
   logic [7:0]                  out_char_ff;
   logic [psx_pkg::LEN_W-1:0]   out_len_ff;
   logic                        out_last_ff;

   logic                        s2_load;
   logic                        s1_load;
   logic                        is_run;
   logic                        last_issue;

   // pipeline advance
   always_comb begin
      s2_load    = s1_valid_ff && (!out_valid_ff || rsp_ready);
      s1_load    = busy_ff && (!s1_valid_ff || s2_load);
      is_run     = (jstat_ff == psx_pkg::ST_ACCEPTED);
      last_issue = !is_run || (psx_pkg::LEN_W'(idx_ff) == (jlen_ff - 1'b1));
      slot_free  = !busy_ff || (s1_load && last_issue);
   end

   // ssid buffer write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (s1_load) begin
         mem_rd_ff <= mem[{jbank_ff, idx_ff}];
      end
   end

   // job sequencing and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (job.valid) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (s1_load) begin
            if (last_issue) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end

         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end

         if (s2_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // job and stage payload
   always_ff @(posedge clock) begin
      if (job.valid) begin
         jstat_ff <= job.status;
         jlen_ff  <= job.length;
         jbank_ff <= job.bank;
      end
      if (s1_load) begin
         s1_status_ff <= jstat_ff;
         s1_len_ff    <= is_run ? jlen_ff : '0;
         s1_last_ff   <= last_issue;
         s1_char_ff   <= is_run;
      end
      if (s2_load) begin
         out_status_ff <= s1_status_ff;
         out_char_ff   <= s1_char_ff ? mem_rd_ff : '0;
         out_len_ff    <= s1_len_ff;
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_char   = out_char_ff;
   assign rsp_length = out_len_ff;
   assign rsp_last   = out_last_ff;

endmodule

`default_nettype wire

// ----- hdl/psx_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module psx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_end_of_frame,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_status,
   input wire logic [7:0] rsp_ssid_char,
   input wire logic [5:0] rsp_ssid_length,
   input wire logic       rsp_last_result
);

   logic       rsp_ok;
   logic [5:0] ssid_max;

   assign rsp_ok   = (rsp_status == psx_pkg::ST_ACCEPTED);
   assign ssid_max = 6'(psx_pkg::SSID_MAX_BYTES);

   // output register comes up empty
   `PSX_ASSERT_NEXT_ALWAYS(a_rsp_empty_after_reset, clock, reset, !rsp_valid)

   // a stalled result word holds
   `PSX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_ssid_char) && $stable(rsp_ssid_length) && $stable(rsp_last_result))

   // status words carry no character and no length, and end their frame
   `PSX_ASSERT_IMPLIES(a_status_clean, clock, reset, rsp_valid && !rsp_ok, (rsp_ssid_char == 8'd0) && (rsp_ssid_length == 6'd0) && rsp_last_result)

   // accepted words carry a length in range
   `PSX_ASSERT_IMPLIES(a_len_range, clock, reset, rsp_valid && rsp_ok, (rsp_ssid_length != 6'd0) && (rsp_ssid_length <= ssid_max))

   // mid-frame bytes never wait
   `PSX_ASSERT_IMPLIES(a_mid_frame_ready, clock, reset, req_valid && !req_end_of_frame, req_ready)

endmodule

bind probe_request_ssid_extractor psx_checker u_psx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_end_of_frame (req_bus.end_of_frame),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_ssid_char    (rsp_bus.ssid_char),
   .rsp_ssid_length  (rsp_bus.ssid_length),
   .rsp_last_result  (rsp_bus.last_result)
);

`default_nettype wire
